@@ hw/rtl/zics_pkg.sv @@
// Shared constants for the Zipf inverse-CDF sampler: request codes, register
// indexes, generator and FNV-1a hash constants, histogram geometry.
// No dependencies.
package zics_pkg;

  // Request codes
  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_DRAW      = 2'd1;
  localparam logic [1:0] OP_READ_HIST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RNG_SEED   = 2'd0;
  localparam logic [1:0] CFG_ENTRIES    = 2'd1;
  localparam logic [1:0] CFG_EMIT_RAW   = 2'd2;
  localparam logic [1:0] CFG_HIST_EN    = 2'd3;

  localparam int SEED_W    = 48;
  localparam int ENTRIES_W = 13;
  localparam int CFG_W     = 48;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 13'd4096;

  // 48-bit linear congruential generator
  localparam logic [34:0] LCG_MUL      = 35'h5DEECE66D;
  localparam logic [23:0] LCG_MUL_LO24 = 24'hECE66D;
  localparam logic [47:0] LCG_ADD      = 48'hB;

  // FNV-1a 64: prime = 2^40 + 0x1B3
  localparam logic [63:0] FNV_BASIS       = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam int          FNV_ROUNDS      = 8;

  // Bit-length histogram
  localparam int HIST_BINS = 65;
  localparam int HIST_AW   = 7;

endpackage

@@ hw/rtl/zipf_inverse_cdf_sampler.sv @@
// Zipf inverse-CDF sampler top level: table memory, histogram memory,
// generator, binary search and FNV-1a hash sequencer.
// Depends on zics_pkg.

// The host loads cumulative probabilities (fractions scaled by 2^48) with load
// requests, then issues draw requests; each draw advances the 48-bit generator,
// binary-searches the table for the first entry not below the new state and
// returns the rank (or its FNV-1a hash) together with the wrapping sum of all
// drawn values. One request is worked at a time. A draw splits the generator
// multiply into two halves, makes one search probe at a time on the table
// memory's single read port, looks up the histogram bin, runs eight FNV-1a
// rounds and hands the result to the output register. A finished result waits
// in the output register, and the next request is taken meanwhile.
module zipf_inverse_cdf_sampler #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [11:0] slot,
  input  logic [48:0] cdf_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [63:0] running_sum
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_SEARCH,
    ST_POST,
    ST_HASH,
    ST_RDH,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration
  logic [zics_pkg::SEED_W-1:0]    generator_state;
  logic [zics_pkg::ENTRIES_W-1:0] entries_in_use;
  logic                           emit_raw_rank;
  logic                           histogram_enable;

  // Memories
  logic [48:0] cdf_mem [TABLE_DEPTH];
  logic [48:0] tbl_rd_data;
  logic [AW-1:0] tbl_rd_addr;
  logic          tbl_rd_en;

  logic [63:0] hist_mem [zics_pkg::HIST_BINS];
  logic [zics_pkg::HIST_BINS-1:0] hist_valid;
  logic [63:0] hist_rd_data;
  logic [zics_pkg::HIST_AW-1:0] hist_rd_addr;
  logic                         hist_rd_en;

  // Work registers
  logic [47:0] prod_lo;
  logic [23:0] prod_hi;
  logic [47:0] x_reg;
  logic [AW-1:0] low, high, mid, rank;
  logic [zics_pkg::HIST_AW-1:0] hist_bin;
  logic        hist_pending;
  logic        rd_in_range;
  logic        is_draw;
  logic [63:0] hash, hash_src;
  logic [2:0]  hash_round;
  logic [63:0] res;
  logic [63:0] draw_sum;

  // Combinational
  logic        in_fire;
  logic [AW-1:0] slot_addr;
  logic        slot_in_table;
  logic        slot_in_hist;
  logic [31:0] n_clamp;
  logic [AW-1:0] high0;
  logic [47:0] x_next;
  logic        le;
  logic [AW-1:0] low_next, high_next, mid_next;
  logic [AW:0]   mid_sum;
  logic [63:0] hash_mix, hash_next;
  logic [zics_pkg::HIST_AW-1:0] rank_bin;
  logic        emit_ok;

  function automatic logic [zics_pkg::HIST_AW-1:0] bit_len(input logic [AW-1:0] v);
    logic [zics_pkg::HIST_AW-1:0] n;
    n = '0;
    for (int i = 0; i < AW; i++) begin
      if (v[i]) n = zics_pkg::HIST_AW'(i + 1);
    end
    return n;
  endfunction

  assign in_stall      = (state != ST_IDLE);
  assign in_fire       = in_valid && !in_stall;
  assign slot_addr     = AW'(slot);
  assign slot_in_table = (32'(slot) < 32'(TABLE_DEPTH));
  assign slot_in_hist  = (32'(slot) < 32'(zics_pkg::HIST_BINS));
  assign emit_ok       = !out_valid || !out_stall;

  always_comb begin
    n_clamp = 32'(entries_in_use);
    if (n_clamp == 32'd0) begin
      n_clamp = 32'd1;
    end else if (n_clamp > 32'(TABLE_DEPTH)) begin
      n_clamp = 32'(TABLE_DEPTH);
    end
    high0 = AW'(n_clamp - 32'd1);
  end

  // Second half of the generator step: combine the registered partial products
  assign x_next = prod_lo + {prod_hi, 24'd0} + zics_pkg::LCG_ADD;

  // One search probe: compare, narrow the range, form the next midpoint
  assign le        = ({1'b0, x_reg} <= tbl_rd_data);
  assign low_next  = le ? low : (mid + AW'(1));
  assign high_next = le ? mid : high;
  assign mid_sum   = {1'b0, low_next} + {1'b0, high_next};
  assign mid_next  = mid_sum[AW:1];

  // One FNV-1a round; multiply by 2^40 + 0x1B3
  assign hash_mix  = hash ^ {56'd0, hash_src[7:0]};
  assign hash_next = (hash_mix << zics_pkg::FNV_PRIME_SHIFT)
                   + 64'(hash_mix * zics_pkg::FNV_PRIME_LO);

  assign rank_bin = bit_len(rank);

  always_comb begin
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = mid_next;
    if (state == ST_GEN) begin
      tbl_rd_en   = (high0 != '0);
      tbl_rd_addr = high0 >> 1;
    end else if (state == ST_SEARCH) begin
      tbl_rd_en   = (low_next != high_next);
    end
  end

  always_comb begin
    hist_rd_en   = 1'b0;
    hist_rd_addr = zics_pkg::HIST_AW'(slot);
    if (state == ST_POST) begin
      hist_rd_en   = 1'b1;
      hist_rd_addr = rank_bin;
    end else if (in_fire && op == zics_pkg::OP_READ_HIST && slot_in_hist) begin
      hist_rd_en   = 1'b1;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (in_fire && op == zics_pkg::OP_LOAD && slot_in_table) begin
      cdf_mem[slot_addr] <= cdf_fraction;
    end
    if (tbl_rd_en) begin
      tbl_rd_data <= cdf_mem[tbl_rd_addr];
    end
  end

  // Histogram memory; an entry never written reads as zero via its valid bit
  always_ff @(posedge clk) begin
    if (state == ST_HASH && hist_pending) begin
      hist_mem[hist_bin] <= (hist_valid[hist_bin] ? hist_rd_data : 64'd0) + 64'd1;
    end
    if (hist_rd_en) begin
      hist_rd_data <= hist_mem[hist_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      hist_valid       <= '0;
      hist_pending     <= 1'b0;
      generator_state  <= '0;
      entries_in_use   <= zics_pkg::ENTRIES_RESET;
      emit_raw_rank    <= 1'b1;
      histogram_enable <= 1'b0;
      draw_sum         <= '0;
    end else begin
      // In ST_EMIT the output register is refilled below instead
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          zics_pkg::CFG_RNG_SEED: generator_state  <= cfg_data[zics_pkg::SEED_W-1:0];
          zics_pkg::CFG_ENTRIES:  entries_in_use   <= cfg_data[zics_pkg::ENTRIES_W-1:0];
          zics_pkg::CFG_EMIT_RAW: emit_raw_rank    <= cfg_data[0];
          zics_pkg::CFG_HIST_EN:  histogram_enable <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            // First half of the generator step: two partial products
            prod_lo     <= {24'd0, generator_state[23:0]} * {13'd0, zics_pkg::LCG_MUL};
            prod_hi     <= 24'(generator_state[47:24] * zics_pkg::LCG_MUL_LO24);
            hist_bin    <= zics_pkg::HIST_AW'(slot);
            rd_in_range <= slot_in_hist;
            if (op == zics_pkg::OP_DRAW) begin
              is_draw <= 1'b1;
              state   <= ST_GEN;
            end else if (op == zics_pkg::OP_READ_HIST) begin
              is_draw <= 1'b0;
              state   <= ST_RDH;
            end
          end
        end
        ST_GEN: begin
          generator_state <= x_next;
          x_reg           <= x_next;
          low             <= '0;
          high            <= high0;
          mid             <= high0 >> 1;
          if (high0 == '0) begin
            rank  <= '0;
            state <= ST_POST;
          end else begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          low  <= low_next;
          high <= high_next;
          mid  <= mid_next;
          if (low_next == high_next) begin
            rank  <= low_next;
            state <= ST_POST;
          end
        end
        ST_POST: begin
          hist_bin     <= rank_bin;
          hist_pending <= histogram_enable;
          hash         <= zics_pkg::FNV_BASIS;
          hash_src     <= 64'(rank);
          hash_round   <= '0;
          state        <= ST_HASH;
        end
        ST_HASH: begin
          if (hist_pending) begin
            hist_valid[hist_bin] <= 1'b1;
            hist_pending         <= 1'b0;
          end
          hash       <= hash_next;
          hash_src   <= hash_src >> 8;
          hash_round <= hash_round + 3'd1;
          if (hash_round == 3'(zics_pkg::FNV_ROUNDS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_RDH: begin
          res   <= (rd_in_range && hist_valid[hist_bin]) ? hist_rd_data : 64'd0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (emit_ok) begin
            out_valid <= 1'b1;
            if (is_draw) begin
              value       <= emit_raw_rank ? 64'(rank) : hash;
              running_sum <= draw_sum + (emit_raw_rank ? 64'(rank) : hash);
              draw_sum    <= draw_sum + (emit_raw_rank ? 64'(rank) : hash);
            end else begin
              value       <= res;
              running_sum <= draw_sum;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (low <= mid) && (mid < high))
    else $error("search midpoint outside its range");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && emit_ok) |=> out_valid && (state == ST_IDLE))
    else $error("result not placed in output register");

  a_sum_only_on_draw: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_EMIT && emit_ok && is_draw) |=> $stable(draw_sum))
    else $error("draw sum changed outside a draw result");

  a_hist_update_after_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HASH && hist_pending) |-> ($past(state) == ST_POST))
    else $error("histogram update without a fresh bin read");
`endif

endmodule
